// ===== rtl/core/wlf_pkg.sv =====
// ----------------------------------------------------------------------------
// wlf_pkg
// Shared types and codes of the per-point running mean / deviation unit.
// ----------------------------------------------------------------------------
package wlf_pkg;

  // Fixed datapath widths, sized for the widest legal parameter values
  localparam int IDX_W  = 16;  // store index (up to 65536 points)
  localparam int X_W    = 40;  // sample as Q16.16, up to 24 sample bits
  localparam int CNT_W  = 32;  // trace count carried with an item
  localparam int DVD_W  = 64;  // divider dividend / quotient width
  localparam int DSR_W  = 33;  // divider divisor width (count plus one)
  localparam int ROOT_W = 32;  // square root result width

  // Input commands
  localparam logic [1:0] CMD_ACCUM      = 2'd0;
  localparam logic [1:0] CMD_TRACE_DONE = 2'd1;
  localparam logic [1:0] CMD_READ       = 2'd2;
  localparam logic [1:0] CMD_CLEAR      = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_VALID   = 2'd0;
  localparam logic [1:0] ST_FEW     = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;

  // Register select (paddr bit 2)
  localparam logic REG_WINDOW_START  = 1'b0;
  localparam logic REG_WINDOW_LENGTH = 1'b1;

  // Item tag that travels down the pipeline
  typedef struct packed {
    logic                    valid;
    logic                    is_read;
    logic                    first;
    logic [IDX_W-1:0]        idx;
    logic [15:0]             pos;
    logic signed [X_W-1:0]   x;
    logic signed [31:0]      mean;
    logic [63:0]             m2;
    logic                    delta_neg;
    logic [CNT_W-1:0]        cnt;
    logic [1:0]              status;
    logic                    sat;
  } tag_t;

  // Store write-back
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] idx;
    logic [31:0]      mean;
    logic [63:0]      m2;
  } wr_t;

endpackage

// ===== rtl/core/wlf_ram.sv =====
// ----------------------------------------------------------------------------
// wlf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module wlf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // Registered read, held between reads
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/wlf_div.sv =====
// ----------------------------------------------------------------------------
// wlf_div
// Pipelined restoring divider, one quotient bit per stage, tag carried along.
// ----------------------------------------------------------------------------
module wlf_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  wlf_pkg::tag_t             tag_in,
  input  logic [wlf_pkg::DVD_W-1:0] dividend,
  input  logic [wlf_pkg::DSR_W-1:0] divisor,
  input  logic [wlf_pkg::IDX_W-1:0] probe_idx,
  output logic                      hit,
  output wlf_pkg::tag_t             tag_out,
  output logic [wlf_pkg::DVD_W-1:0] quotient
);
  import wlf_pkg::*;

  tag_t             tg  [DVD_W];
  logic [DSR_W-1:0] rem [DVD_W];
  logic [DSR_W-1:0] dsr [DVD_W];
  logic [DVD_W-1:0] dvd [DVD_W];
  logic [DVD_W-1:0] quo [DVD_W];

  for (genvar s = 0; s < DVD_W; s++) begin : g_stage
    tag_t             pt;
    logic [DSR_W-1:0] pr;
    logic [DSR_W-1:0] pd;
    logic [DVD_W-1:0] pv;
    logic [DVD_W-1:0] pq;
    logic [DSR_W:0]   trial;
    logic             ge;

    if (s == 0) begin : g_head
      assign pt = tag_in;
      assign pr = '0;
      assign pd = divisor;
      assign pv = dividend;
      assign pq = '0;
    end else begin : g_body
      assign pt = tg[s-1];
      assign pr = rem[s-1];
      assign pd = dsr[s-1];
      assign pv = dvd[s-1];
      assign pq = quo[s-1];
    end

    // Shift in the next dividend bit and try a subtract
    assign trial = {pr, pv[DVD_W-1]};
    assign ge    = trial >= {1'b0, pd};

    always_ff @(posedge clk) begin
      if (rst) begin
        tg[s].valid <= 1'b0;
      end else if (en) begin
        tg[s]  <= pt;
        rem[s] <= ge ? DSR_W'(trial - {1'b0, pd}) : trial[DSR_W-1:0];
        dsr[s] <= pd;
        dvd[s] <= {pv[DVD_W-2:0], 1'b0};
        quo[s] <= {pq[DVD_W-2:0], ge};
      end
    end
  end

  // Flag an in-flight accumulate on the probed entry
  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < DVD_W; i++) begin
      if (tg[i].valid && !tg[i].is_read && tg[i].idx == probe_idx) hit = 1'b1;
    end
  end

  assign tag_out  = tg[DVD_W-1];
  assign quotient = quo[DVD_W-1];

endmodule

// ===== rtl/core/wlf_upd.sv =====
// ----------------------------------------------------------------------------
// wlf_upd
// Welford update tail: new mean, deviation product, M2 update and write-back.
// ----------------------------------------------------------------------------
module wlf_upd (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  wlf_pkg::tag_t             tag_in,
  input  logic [63:0]               q,
  input  logic [wlf_pkg::IDX_W-1:0] probe_idx,
  output logic                      hit,
  output wlf_pkg::wr_t              wr,
  output wlf_pkg::tag_t             tag_out,
  output logic [63:0]               radicand
);
  import wlf_pkg::*;

  tag_t        t1, t2, t3, t4, t5;
  logic [31:0] nm1, nm2, nm3, nm4;
  logic [63:0] q1, q2, q3, q4;
  logic [63:0] a2, b2;
  logic        add2, add3, add4;
  logic [63:0] pp_ll, pp_lh, pp_hl, pp_hh;
  logic [63:0] prod4;
  logic [63:0] rad5;

  // Stage 1: mean plus signed quotient, or first sample, saturated to 32 bits
  logic signed [65:0] qs, sumw;
  logic [31:0]        xsat, nmsat, nm1_next;
  always_comb begin
    qs   = tag_in.delta_neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
    sumw = $signed({{34{tag_in.mean[31]}}, tag_in.mean}) + qs;
    if (sumw[65:31] == '0 || sumw[65:31] == '1) nmsat = sumw[31:0];
    else nmsat = sumw[65] ? 32'h8000_0000 : 32'h7fff_ffff;
    if (tag_in.x[X_W-1:31] == '0 || tag_in.x[X_W-1:31] == '1) xsat = tag_in.x[31:0];
    else xsat = tag_in.x[X_W-1] ? 32'h8000_0000 : 32'h7fff_ffff;
    nm1_next = tag_in.first ? xsat : nmsat;
  end

  // Stage 2: magnitudes of old and new deviation
  logic [41:0] d42, e42, amag, bmag;
  logic        neg;
  always_comb begin
    d42  = {{2{t1.x[X_W-1]}}, t1.x} - {{10{t1.mean[31]}}, t1.mean};
    e42  = {{2{t1.x[X_W-1]}}, t1.x} - {{10{nm1[31]}}, nm1};
    amag = d42[41] ? -d42 : d42;
    bmag = e42[41] ? -e42 : e42;
    neg  = d42[41] != e42[41];
  end

  // Stage 4: combine partial products, saturate, drop fraction bits
  logic [129:0] psum;
  logic [63:0]  prod_next;
  always_comb begin
    psum = 130'(pp_ll) + (130'(pp_lh) << 32) + (130'(pp_hl) << 32) + (130'(pp_hh) << 64);
    prod_next = (|psum[129:64] ? 64'hffff_ffff_ffff_ffff : psum[63:0]) >> 16;
  end

  // Stage 5: M2 update with saturation at both ends
  logic [63:0] m2_new;
  tag_t        t5_next;
  always_comb begin
    if (t4.first) m2_new = '0;
    else if (add4) m2_new = (t4.m2 > ~prod4) ? 64'hffff_ffff_ffff_ffff : t4.m2 + prod4;
    else m2_new = (t4.m2 > prod4) ? t4.m2 - prod4 : 64'd0;
    t5_next     = t4;
    t5_next.sat = |q4[63:48];
    wr.we   = en && t4.valid && !t4.is_read;
    wr.idx  = t4.idx;
    wr.mean = nm4;
    wr.m2   = m2_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t1.valid <= 1'b0;
      t2.valid <= 1'b0;
      t3.valid <= 1'b0;
      t4.valid <= 1'b0;
      t5.valid <= 1'b0;
    end else if (en) begin
      t1 <= tag_in;
      t2 <= t1;
      t3 <= t2;
      t4 <= t3;
      t5 <= t5_next;
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      nm1   <= nm1_next;
      q1    <= q;
      nm2   <= nm1;
      q2    <= q1;
      a2    <= {22'b0, amag};
      b2    <= {22'b0, bmag};
      add2  <= (amag == '0) || (bmag == '0) || !neg;
      nm3   <= nm2;
      q3    <= q2;
      add3  <= add2;
      pp_ll <= a2[31:0]  * b2[31:0];
      pp_lh <= a2[31:0]  * b2[63:32];
      pp_hl <= a2[63:32] * b2[31:0];
      pp_hh <= a2[63:32] * b2[63:32];
      nm4   <= nm3;
      q4    <= q3;
      add4  <= add3;
      prod4 <= prod_next;
      rad5  <= {q4[47:0], 16'h0000};
    end
  end

  // Flag an in-flight accumulate on the probed entry
  always_comb begin
    hit = (t1.valid && !t1.is_read && t1.idx == probe_idx) ||
          (t2.valid && !t2.is_read && t2.idx == probe_idx) ||
          (t3.valid && !t3.is_read && t3.idx == probe_idx) ||
          (t4.valid && !t4.is_read && t4.idx == probe_idx);
  end

  assign tag_out  = t5;
  assign radicand = rad5;

endmodule

// ===== rtl/core/wlf_sqrt.sv =====
// ----------------------------------------------------------------------------
// wlf_sqrt
// Pipelined integer square root, one result bit per stage, tag carried along.
// ----------------------------------------------------------------------------
module wlf_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  wlf_pkg::tag_t              tag_in,
  input  logic [2*wlf_pkg::ROOT_W-1:0] radicand,
  output wlf_pkg::tag_t              tag_out,
  output logic [wlf_pkg::ROOT_W-1:0] root
);
  import wlf_pkg::*;

  localparam int REM_W = ROOT_W + 3;
  localparam int RAD_W = 2 * ROOT_W;

  tag_t              tg  [ROOT_W];
  logic [REM_W-1:0]  rem [ROOT_W];
  logic [ROOT_W-1:0] rt  [ROOT_W];
  logic [RAD_W-1:0]  rad [ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    tag_t              pt;
    logic [REM_W-1:0]  pr;
    logic [ROOT_W-1:0] pq;
    logic [RAD_W-1:0]  pv;
    logic [REM_W-1:0]  trial;
    logic [REM_W-1:0]  tst;
    logic              ge;

    if (s == 0) begin : g_head
      assign pt = tag_in;
      assign pr = '0;
      assign pq = '0;
      assign pv = radicand;
    end else begin : g_body
      assign pt = tg[s-1];
      assign pr = rem[s-1];
      assign pq = rt[s-1];
      assign pv = rad[s-1];
    end

    // Bring in two radicand bits and test root*4+1
    assign trial = {pr[REM_W-3:0], pv[RAD_W-1:RAD_W-2]};
    assign tst   = REM_W'({pq, 2'b01});
    assign ge    = trial >= tst;

    always_ff @(posedge clk) begin
      if (rst) begin
        tg[s].valid <= 1'b0;
      end else if (en) begin
        tg[s]  <= pt;
        rem[s] <= ge ? trial - tst : trial;
        rt[s]  <= {pq[ROOT_W-2:0], ge};
        rad[s] <= {pv[RAD_W-3:0], 2'b00};
      end
    end
  end

  assign tag_out = tg[ROOT_W-1];
  assign root    = rt[ROOT_W-1];

endmodule

// ===== rtl/core/per_point_running_mean_stddev_unit.sv =====
// ----------------------------------------------------------------------------
// per_point_running_mean_stddev_unit
// Per-position running mean and standard deviation over many traces.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis_*): tuser carries the command (accumulate, trace
//   finished, read, clear count); tdata carries sample position and sample.
//   Output stream (m_axis_*): one transaction per read command, with
//   position, Q16.16 mean, Q16.16 deviation and trace count; tuser is status.
//   APB port: window_start at 0x0, window_length at 0x4, write while idle.
// Throughput and pipeline depth:
//   One transaction per cycle is accepted unless the pipeline is halted or
//   a hazard holds the input. A read result passes 104 registers: entry
//   and store read (2), 64-stage divider, 5-stage update tail, 32-stage
//   square root and the output register.
//   An accumulate or read that hits a position with an accumulate still in
//   flight waits until that write-back lands.
// Reset:
//   Zeroes the trace counter and window_start, sets window_length to 4096 and
//   clears all valid bits, not the stores; accumulates at count zero overwrite.
// Stall:
//   A waiting result sits in the output register while the pipeline keeps
//   moving; it halts only when a new result reaches its end while one waits.
// ----------------------------------------------------------------------------
module per_point_running_mean_stddev_unit #(
  parameter int MAX_POINTS  = 4096,
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 24
) (
  input  logic        clk,
  input  logic        rst,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] sample_position, [16+SAMPLE_BITS-1:16] sample_value, zero padded
  input  logic [((16+SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // [1:0] command
  input  logic [1:0]  s_axis_tuser,
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] position_echo, [47:16] mean_value, [79:48] std_deviation,
  // [103:80] traces_seen
  output logic [103:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0]  m_axis_tuser
);
  import wlf_pkg::*;

  localparam int IW = $clog2(MAX_POINTS);

  logic [15:0]           window_start;
  logic [12:0]           window_length;
  logic [COUNT_BITS-1:0] trace_counter;

  // Configuration registers
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      window_start  <= 16'd0;
      window_length <= 13'd4096;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_WINDOW_START:  window_start  <= pwdata[15:0];
        REG_WINDOW_LENGTH: window_length <= pwdata[12:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WINDOW_START:  prdata = {16'd0, window_start};
      REG_WINDOW_LENGTH: prdata = {19'd0, window_length};
    endcase
  end

  // Entry: window test and hazard check
  logic [1:0]             s_cmd;
  logic [15:0]            s_pos;
  logic [SAMPLE_BITS-1:0] s_val;
  logic [16:0]            off;
  logic                   in_win, touches, enters, hit_any, accept, pipe_en;
  logic                   div_hit, upd_hit;
  logic [IDX_W-1:0]       probe;
  tag_t                   s1, s1_next, s2, s2_next;

  assign s_cmd   = s_axis_tuser;
  assign s_pos   = s_axis_tdata[15:0];
  assign s_val   = s_axis_tdata[16 +: SAMPLE_BITS];
  assign off     = {1'b0, s_pos} - {1'b0, window_start};
  assign in_win  = !off[16] && (off[15:0] < {3'b000, window_length}) &&
                   (off < 17'(MAX_POINTS));
  assign touches = in_win && (s_cmd == CMD_ACCUM || s_cmd == CMD_READ);
  assign enters  = (s_cmd == CMD_READ) || (s_cmd == CMD_ACCUM && in_win);
  assign probe   = off[15:0];
  assign hit_any = touches && (div_hit || upd_hit ||
                   (s1.valid && !s1.is_read && s1.idx == probe) ||
                   (s2.valid && !s2.is_read && s2.idx == probe));
  assign s_axis_tready = pipe_en && !hit_any;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    s1_next           = '0;
    s1_next.valid     = accept && enters;
    s1_next.is_read   = s_cmd == CMD_READ;
    s1_next.first     = trace_counter == '0;
    s1_next.idx       = off[15:0];
    s1_next.pos       = s_pos;
    s1_next.x         = X_W'($signed(s_val)) <<< 16;
    s1_next.cnt       = CNT_W'(trace_counter);
    if (!in_win) s1_next.status = ST_OUTSIDE;
    else if (s_cmd == CMD_READ && trace_counter < COUNT_BITS'(2)) s1_next.status = ST_FEW;
    else s1_next.status = ST_VALID;
  end

  // Trace counter
  always_ff @(posedge clk) begin
    if (rst) begin
      trace_counter <= '0;
    end else if (accept) begin
      unique case (s_cmd)
        CMD_TRACE_DONE: if (!(&trace_counter)) trace_counter <= trace_counter + 1'b1;
        CMD_CLEAR:      trace_counter <= '0;
        CMD_ACCUM,
        CMD_READ:       trace_counter <= trace_counter;
      endcase
    end
  end

  // Stores
  wr_t         mem_wr;
  logic [31:0] rd_mean;
  logic [63:0] rd_m2;

  wlf_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_mean_ram (
    .clk   (clk),
    .we    (mem_wr.we),
    .waddr (mem_wr.idx[IW-1:0]),
    .wdata (mem_wr.mean),
    .re    (accept && touches),
    .raddr (off[IW-1:0]),
    .rdata (rd_mean)
  );

  wlf_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_m2_ram (
    .clk   (clk),
    .we    (mem_wr.we),
    .waddr (mem_wr.idx[IW-1:0]),
    .wdata (mem_wr.m2),
    .re    (accept && touches),
    .raddr (off[IW-1:0]),
    .rdata (rd_m2)
  );

  // Stage 2: deviation from stored mean and divider operands
  logic [31:0]      mean_rd;
  logic [41:0]      d42, dmag;
  logic [DVD_W-1:0] dvd_next, s2_dvd;
  logic [DSR_W-1:0] dsr_next, s2_dsr;
  always_comb begin
    mean_rd = (s1.status == ST_OUTSIDE) ? 32'd0 : rd_mean;
    d42     = {{2{s1.x[X_W-1]}}, s1.x} - {{10{mean_rd[31]}}, mean_rd};
    dmag    = d42[41] ? -d42 : d42;
    s2_next           = s1;
    s2_next.mean      = mean_rd;
    s2_next.m2        = rd_m2;
    s2_next.delta_neg = d42[41];
    if (s1.is_read) begin
      dvd_next = rd_m2;
      dsr_next = (s1.status == ST_VALID) ? {1'b0, s1.cnt} - 33'd1 : 33'd1;
    end else begin
      dvd_next = {22'd0, dmag};
      dsr_next = {1'b0, s1.cnt} + 33'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      s2.valid <= 1'b0;
    end else if (pipe_en) begin
      s1     <= s1_next;
      s2     <= s2_next;
      s2_dvd <= dvd_next;
      s2_dsr <= dsr_next;
    end
  end

  // Divider, update tail, square root
  tag_t              dv_tag, up_tag, sq_tag;
  logic [DVD_W-1:0]  dv_q;
  logic [63:0]       up_rad;
  logic [ROOT_W-1:0] sq_root;

  wlf_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (pipe_en),
    .tag_in    (s2),
    .dividend  (s2_dvd),
    .divisor   (s2_dsr),
    .probe_idx (probe),
    .hit       (div_hit),
    .tag_out   (dv_tag),
    .quotient  (dv_q)
  );

  wlf_upd u_upd (
    .clk       (clk),
    .rst       (rst),
    .en        (pipe_en),
    .tag_in    (dv_tag),
    .q         (dv_q),
    .probe_idx (probe),
    .hit       (upd_hit),
    .wr        (mem_wr),
    .tag_out   (up_tag),
    .radicand  (up_rad)
  );

  wlf_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (pipe_en),
    .tag_in   (up_tag),
    .radicand (up_rad),
    .tag_out  (sq_tag),
    .root     (sq_root)
  );

  // Output register; halt the pipeline only when a new result cannot land
  logic        last_read;
  logic        m_valid;
  logic [15:0] m_pos;
  logic [31:0] m_mean, m_std;
  logic [23:0] m_cnt;
  logic [1:0]  m_status;

  assign last_read = sq_tag.valid && sq_tag.is_read;
  assign pipe_en   = !(last_read && m_valid && !m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (last_read && pipe_en) begin
      m_valid <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (last_read && pipe_en) begin
      m_pos    <= sq_tag.pos;
      m_mean   <= (sq_tag.status == ST_OUTSIDE) ? 32'd0 : sq_tag.mean;
      m_cnt    <= sq_tag.cnt[23:0];
      m_status <= sq_tag.status;
      if (sq_tag.status != ST_VALID) m_std <= 32'd0;
      else if (sq_tag.sat) m_std <= 32'hffff_ffff;
      else m_std <= sq_root;
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {m_cnt, m_std, m_mean, m_pos};
  assign m_axis_tuser  = m_status;

  // Checks
  a_clear_count: assert property (@(posedge clk) disable iff (rst)
    (accept && s_cmd == CMD_CLEAR) |=> (trace_counter == '0))
    else $error("trace counter not cleared");

  a_wr_moves: assert property (@(posedge clk) disable iff (rst)
    mem_wr.we |-> pipe_en)
    else $error("store written while pipeline halted");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    (m_valid && m_status == ST_OUTSIDE) |-> (m_mean == 32'd0 && m_std == 32'd0))
    else $error("outside-window result carries data");

  a_hazard_block: assert property (@(posedge clk) disable iff (rst)
    (s1.valid && !s1.is_read && touches && s1.idx == probe) |-> !accept)
    else $error("accepted an item on an entry with a pending update");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the per-point running mean / deviation unit: traces are
// folded into a windowed set of positions, statistics are read back and each
// read result is compared against a Welford predictor kept in this bench.
// ----------------------------------------------------------------------------
module tb_top;
  import wlf_pkg::*;

  localparam int NPOINTS     = 4096;
  localparam int DRAIN_WAIT  = 130;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic [15:0] pos;
    logic [31:0] mean;
    logic [31:0] dev;
    logic [23:0] seen;
    logic [1:0]  status;
  } stat_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // [15:0] sample_position, [31:16] sample_value
  logic [31:0] s_axis_tdata = '0;
  // [1:0] command
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // [15:0] position_echo, [47:16] mean_value, [79:48] std_deviation,
  // [103:80] traces_seen
  logic [103:0] m_axis_tdata;
  // [1:0] status
  logic [1:0] m_axis_tuser;

  // Predictor state
  logic [15:0]        win_start = 16'd0;
  logic [12:0]        win_len = 13'd4096;
  logic signed [31:0] mean_mem [NPOINTS];
  logic [63:0]        m2_mem [NPOINTS];
  logic               written [NPOINTS];
  logic [23:0]        trace_cnt = '0;
  stat_result_t       pending_reads [$];

  int errors = 0;
  int cycles = 0;
  int sent_items = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_off = 0;
  int base_val = 0;

  per_point_running_mean_stddev_unit dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always #5 clk = ~clk;

  // Abort on runaway
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: long hold-off first, otherwise random stalls
  always @(posedge clk) begin
    if (hold_off > 0) begin
      m_axis_tready <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Compare each output transaction with the oldest expected read
  always @(negedge clk) begin
    stat_result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[15:0], m_axis_tdata[47:16], m_axis_tdata[79:48],
             m_axis_tdata[103:80], m_axis_tuser};
      if (pending_reads.size() == 0) begin
        $error("unexpected result transaction, position %0d", got.pos);
        errors++;
      end else begin
        want = pending_reads.pop_front();
        if (got.pos !== want.pos) begin
          $error("position_echo: expected %0d, got %0d", want.pos, got.pos); errors++;
        end
        if (got.mean !== want.mean) begin
          $error("mean_value: expected %0h, got %0h", want.mean, got.mean); errors++;
        end
        if (got.dev !== want.dev) begin
          $error("std_deviation: expected %0h, got %0h", want.dev, got.dev); errors++;
        end
        if (got.seen !== want.seen) begin
          $error("traces_seen: expected %0d, got %0d", want.seen, got.seen); errors++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status); errors++;
        end
      end
    end
  end

  function automatic logic in_win(input logic [15:0] pos, output int idx);
    int off;
    off = int'(pos) - int'(win_start);
    idx = off;
    return (off >= 0) && (off < int'(win_len)) && (off < NPOINTS);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] r);
    logic [63:0] res, bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > r) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (r >= res + bitv) begin
        r = r - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Welford update of one entry
  task automatic fold_sample(input int idx, input logic signed [15:0] val);
    longint x, mean, delta, nm, diff, n;
    logic [63:0] a, b, prod, m2;
    logic [127:0] wide;
    logic neg;
    x = longint'(val) * 65536;
    n = longint'(trace_cnt) + 1;
    if (n == 1) begin
      mean_mem[idx] = x[31:0];
      m2_mem[idx] = '0;
      written[idx] = 1'b1;
      return;
    end
    mean = longint'(mean_mem[idx]);
    delta = x - mean;
    nm = mean + delta / n;
    if (nm > 64'sd2147483647) nm = 64'sd2147483647;
    if (nm < -64'sd2147483648) nm = -64'sd2147483648;
    diff = x - nm;
    a = (delta < 0) ? -delta : delta;
    b = (diff < 0) ? -diff : diff;
    neg = (delta < 0) != (diff < 0);
    wide = {64'd0, a} * {64'd0, b};
    prod = (wide[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : wide[63:0];
    prod = prod >> 16;
    m2 = m2_mem[idx];
    if (a == 0 || b == 0 || !neg)
      m2 = (m2 > ~prod) ? 64'hFFFF_FFFF_FFFF_FFFF : m2 + prod;
    else
      m2 = (m2 > prod) ? m2 - prod : 64'd0;
    mean_mem[idx] = nm[31:0];
    m2_mem[idx] = m2;
  endtask

  // Advance the predictor by one accepted transaction
  task automatic predict(input logic [1:0] cmd, input logic [15:0] pos,
                         input logic [15:0] val);
    int idx;
    stat_result_t r;
    logic [63:0] v;
    case (cmd)
      CMD_ACCUM: begin
        if (in_win(pos, idx)) fold_sample(idx, val);
      end
      CMD_TRACE_DONE: begin
        if (trace_cnt != 24'hFF_FFFF) trace_cnt++;
      end
      CMD_CLEAR: begin
        trace_cnt = '0;
      end
      default: begin
        r.pos = pos;
        r.seen = trace_cnt;
        if (!in_win(pos, idx)) begin
          r.mean = '0; r.dev = '0; r.status = ST_OUTSIDE;
        end else begin
          r.mean = mean_mem[idx];
          if (trace_cnt < 2) begin
            r.dev = '0; r.status = ST_FEW;
          end else begin
            v = m2_mem[idx] / (64'(trace_cnt) - 1);
            r.dev = (v >= (64'd1 << 48)) ? 32'hFFFF_FFFF : 32'(int_sqrt(v << 16));
            r.status = ST_VALID;
          end
        end
        pending_reads.push_back(r);
      end
    endcase
  endtask

  // Offer one item; skip reads and later-trace accumulates to unwritten entries
  task automatic send_item(input logic [1:0] cmd, input logic [15:0] pos,
                           input logic [15:0] val);
    int idx;
    logic ok;
    if (in_win(pos, idx) && !written[idx] &&
        (cmd == CMD_READ || (cmd == CMD_ACCUM && trace_cnt != 0))) return;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {val, pos};
    s_axis_tuser <= cmd;
    ok = 1'b0;
    while (!ok) begin
      @(negedge clk);
      ok = s_axis_tready;
      @(posedge clk);
    end
    predict(cmd, pos, val);
    sent_items++;
    if ($urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Hold input, wait for all reads, then let accumulates land
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic cfg_write(input logic sel, input logic [31:0] value);
    drain();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {sel, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (sel == REG_WINDOW_START) win_start = value[15:0];
    else win_len = value[12:0];
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_value();
    int t;
    if ($urandom_range(0, 2) == 0) return 16'($urandom());
    t = base_val + $urandom_range(0, 400) - 200;
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    return 16'(t);
  endfunction

  // One well-formed trace across the window, with reads mixed in
  task automatic run_trace(input int read_pct);
    for (int p = 0; p < int'(win_len); p++) begin
      send_item(CMD_ACCUM, win_start + 16'(p), pick_value());
      if ($urandom_range(0, 99) < read_pct)
        send_item(CMD_READ, win_start + 16'($urandom_range(0, win_len - 1)), 16'($urandom()));
    end
    send_item(CMD_TRACE_DONE, 16'($urandom()), 16'($urandom()));
  endtask

  task automatic read_window();
    for (int p = 0; p < int'(win_len); p++)
      send_item(CMD_READ, win_start + 16'(p), 16'($urandom()));
  endtask

  task automatic test_directed();
    cfg_write(REG_WINDOW_START, 32'd0);
    cfg_write(REG_WINDOW_LENGTH, 32'd4);
    send_item(CMD_CLEAR, 16'hFFFF, 16'hFFFF);
    send_item(CMD_ACCUM, 16'd0, 16'h7FFF);
    send_item(CMD_ACCUM, 16'd1, 16'h8000);
    send_item(CMD_ACCUM, 16'd2, 16'h0000);
    send_item(CMD_ACCUM, 16'd3, 16'h0001);
    send_item(CMD_READ, 16'd0, 16'h0);
    send_item(CMD_TRACE_DONE, 16'd0, 16'h0);
    send_item(CMD_READ, 16'd1, 16'h0);
    send_item(CMD_READ, 16'd4, 16'h0);
    send_item(CMD_READ, 16'hFFFF, 16'h0);
    send_item(CMD_ACCUM, 16'd0, 16'h8000);
    send_item(CMD_ACCUM, 16'd1, 16'h7FFF);
    send_item(CMD_ACCUM, 16'd2, 16'hFFFF);
    send_item(CMD_ACCUM, 16'd3, 16'h0001);
    send_item(CMD_ACCUM, 16'd9, 16'h1234);
    send_item(CMD_TRACE_DONE, 16'd0, 16'h0);
    read_window();
    send_item(CMD_CLEAR, 16'd0, 16'h0);
    send_item(CMD_READ, 16'd0, 16'h0);
    send_item(CMD_ACCUM, 16'd0, 16'h0100);
    send_item(CMD_READ, 16'd0, 16'h0);
  endtask

  task automatic test_window_edges();
    cfg_write(REG_WINDOW_START, 32'd65535);
    cfg_write(REG_WINDOW_LENGTH, 32'd1);
    send_item(CMD_CLEAR, 16'd0, 16'h0);
    repeat (4) run_trace(50);
    send_item(CMD_READ, 16'hFFFF, 16'h0);
    send_item(CMD_READ, 16'hFFFE, 16'h0);
    send_item(CMD_READ, 16'h0000, 16'h0);
    cfg_write(REG_WINDOW_START, 32'd100);
    cfg_write(REG_WINDOW_LENGTH, 32'd4096);
    send_item(CMD_CLEAR, 16'd0, 16'h0);
    repeat (4) begin
      send_item(CMD_ACCUM, 16'd100, pick_value());
      send_item(CMD_ACCUM, 16'd4195, pick_value());
      send_item(CMD_ACCUM, 16'd4196, pick_value());
      send_item(CMD_TRACE_DONE, 16'd0, 16'h0);
      send_item(CMD_READ, 16'd4195, 16'h0);
    end
    send_item(CMD_READ, 16'd100, 16'h0);
    send_item(CMD_READ, 16'd99, 16'h0);
    send_item(CMD_READ, 16'd4196, 16'h0);
  endtask

  // Random window, mostly whole traces, some noise and counter clears
  task automatic test_random(input int gap, input int stall, input int quota);
    int len, stop_at;
    gap_pct = 0; stall_pct = 0;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
    cfg_write(REG_WINDOW_LENGTH, 32'(len));
    cfg_write(REG_WINDOW_START, 32'($urandom_range(0, 65536 - len)));
    gap_pct = gap; stall_pct = stall;
    base_val = $urandom_range(0, 65535) - 32768;
    send_item(CMD_CLEAR, 16'($urandom()), 16'($urandom()));
    stop_at = sent_items + quota;
    while (sent_items < stop_at) begin
      if ($urandom_range(0, 99) < 85) begin
        run_trace(25);
      end else begin
        case ($urandom_range(0, 3))
          0: send_item(CMD_ACCUM, 16'($urandom()), 16'($urandom()));
          1: send_item(CMD_READ, 16'($urandom()), 16'($urandom()));
          2: send_item(CMD_CLEAR, 16'($urandom()), 16'($urandom()));
          default: send_item(CMD_READ,
                             win_start + 16'($urandom_range(0, win_len - 1)), 16'h0);
        endcase
      end
    end
    read_window();
  endtask

  // Stall the output long enough to back up the pipeline into the input
  task automatic test_backpressure();
    gap_pct = 0; stall_pct = 0;
    cfg_write(REG_WINDOW_START, 32'd40);
    cfg_write(REG_WINDOW_LENGTH, 32'd4);
    send_item(CMD_CLEAR, 16'd0, 16'h0);
    repeat (3) run_trace(0);
    hold_off = 600;
    repeat (40) read_window();
  endtask

  initial begin
    for (int i = 0; i < NPOINTS; i++) written[i] = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_window_edges();
    test_random(0, 0, 45);
    test_random(61, 0, 45);
    test_random(0, 61, 45);
    test_random(35, 35, 45);
    test_backpressure();
    gap_pct = 0; stall_pct = 0;
    drain();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/wlf_pkg.sv
rtl/core/wlf_ram.sv
rtl/core/wlf_div.sv
rtl/core/wlf_upd.sv
rtl/core/wlf_sqrt.sv
rtl/core/per_point_running_mean_stddev_unit.sv
tb/tb_top.sv
